[design/lrbm_pkg.sv]
// ----------------------------------------------------------------------------
// lrbm_pkg
// Shared constants for the lidar robot box mask: widths, register indexes,
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lrbm_pkg;

    localparam int MAX_ROBOTS    = 3;
    localparam int MAX_SAMPLES   = 4096;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_COUNT    = 24;
    localparam int ROBOT_SLOTS   = 3;

    localparam int CORDIC_N  = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
    localparam int NUM_CHECK = (MAX_ROBOTS < ROBOT_SLOTS) ? MAX_ROBOTS : ROBOT_SLOTS;

    localparam int RANGE_W  = 16;
    localparam int INDEX_W  = 12;
    localparam int ANGLE_W  = 16;
    localparam int POS_W    = 16;
    localparam int HW_W     = 15;
    localparam int XY_W     = 27;        // rotated vector, 8 extra fraction bits
    localparam int Z_W      = 33;        // residual angle, 2^-32 turn
    localparam int PXY_W    = XY_W - 8;
    localparam int DIFF_W   = PXY_W + 1;
    localparam int SAMPLE_CMP_W = 17;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_START_ANGLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROBOT_POS_0 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROBOT_POS_1 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROBOT_POS_2 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ROBOT_EN    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_WIDTH  = 3'd6;

    localparam logic [RANGE_W-1:0] NO_RETURN        = 16'hFFFF;
    localparam logic [RANGE_W-1:0] INV_GAIN         = 16'd39797;
    localparam logic [HW_W-1:0]    HALF_WIDTH_RESET = 15'd205;
    localparam logic [ANGLE_W-1:0] OCTANT_BIAS      = 16'h2000;

    // atan(2^-i) in 2^-32 turn
    localparam logic signed [Z_W-1:0] ATAN_TURN [ATAN_COUNT] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

endpackage

[design/lidar_robot_box_mask.sv]
// ----------------------------------------------------------------------------
// lidar_robot_box_mask
// Rotates each lidar range sample into x,y with a pipelined CORDIC and blanks
// samples that fall inside the box around an enabled robot position.
// ----------------------------------------------------------------------------
//
//  channel  | direction | item contents
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | tdata: sample_range, sample_index
//  m_*      | out       | tdata: filtered_range; tuser: was_masked
//  cfg_*    | in        | register write: index, data (no read-back)
//
// One item per clock sustained while m_tready is high. CORDIC_STAGES + 4 register
// slots: angle, gain/quadrant, one per CORDIC iteration, rotate/round, box
// compare; the result is registered in the box compare slot and drives m_*.
// Reset clears the stage valid bits and loads the register defaults.
// A stall on m_tready fills the pipe; each stage holds only while the one
// after it is full, so bubbles squeeze out and s_tready drops only when full.
module lidar_robot_box_mask (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] sample_range, [27:16] sample_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] filtered_range
    output logic        m_tuser,    // [0] was_masked
    input  logic                             cfg_we,
    input  logic [lrbm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lrbm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int N    = lrbm_pkg::CORDIC_N;
    localparam int NSTG = N + 4;
    localparam int SRND = N + 2;    // rotate/round slot
    localparam int SOUT = N + 3;    // output slot

    // ---------------- configuration ----------------
    logic [lrbm_pkg::ANGLE_W-1:0]    start_angle_reg;
    logic [lrbm_pkg::ANGLE_W-1:0]    angle_step_reg;
    logic [lrbm_pkg::CFG_DATA_W-1:0] robot_pos_reg [lrbm_pkg::ROBOT_SLOTS];
    logic [lrbm_pkg::ROBOT_SLOTS-1:0] robot_en_reg;
    logic [lrbm_pkg::HW_W-1:0]       half_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            for (int k = 0; k < lrbm_pkg::ROBOT_SLOTS; k++) begin
                robot_pos_reg[k] <= '0;
            end
            robot_en_reg    <= '0;
            half_width_reg  <= lrbm_pkg::HALF_WIDTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                lrbm_pkg::REG_START_ANGLE: start_angle_reg  <= cfg_wdata[lrbm_pkg::ANGLE_W-1:0];
                lrbm_pkg::REG_ANGLE_STEP:  angle_step_reg   <= cfg_wdata[lrbm_pkg::ANGLE_W-1:0];
                lrbm_pkg::REG_ROBOT_POS_0: robot_pos_reg[0] <= cfg_wdata;
                lrbm_pkg::REG_ROBOT_POS_1: robot_pos_reg[1] <= cfg_wdata;
                lrbm_pkg::REG_ROBOT_POS_2: robot_pos_reg[2] <= cfg_wdata;
                lrbm_pkg::REG_ROBOT_EN:    robot_en_reg <= cfg_wdata[lrbm_pkg::ROBOT_SLOTS-1:0];
                lrbm_pkg::REG_HALF_WIDTH:  half_width_reg   <= cfg_wdata[lrbm_pkg::HW_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage flow control ----------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = (adv & {vld_reg[NSTG-2:0], s_tvalid}) | (~adv & vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NSTG-1];

    // ---------------- range / active carried along ----------------
    logic [lrbm_pkg::RANGE_W-1:0] rng_reg [SOUT];
    logic                         act_reg [SOUT];

    logic [lrbm_pkg::RANGE_W-1:0] s_range;
    logic [lrbm_pkg::INDEX_W-1:0] s_index;
    logic                         s_active;

    assign s_range  = s_tdata[15:0];
    assign s_index  = s_tdata[27:16];
    assign s_active = (s_range != lrbm_pkg::NO_RETURN) &&
                      (lrbm_pkg::SAMPLE_CMP_W'(s_index) <
                       lrbm_pkg::SAMPLE_CMP_W'(lrbm_pkg::MAX_SAMPLES));

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            rng_reg[0] <= s_range;
            act_reg[0] <= s_active;
        end
        for (int s = 1; s < SOUT; s++) begin
            if (adv[s]) begin
                rng_reg[s] <= rng_reg[s-1];
                act_reg[s] <= act_reg[s-1];
            end
        end
    end

    // ---------------- slot 0: beam angle ----------------
    logic [lrbm_pkg::ANGLE_W-1:0] idx_wide;
    logic [lrbm_pkg::ANGLE_W-1:0] ang_prod;
    logic [lrbm_pkg::ANGLE_W-1:0] ang_reg;

    assign idx_wide = lrbm_pkg::ANGLE_W'(s_index);
    assign ang_prod = idx_wide * angle_step_reg;    // wraps mod one turn

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ang_reg <= start_angle_reg + ang_prod;
        end
    end

    // ---------------- slot 1: quadrant, residual, gain ----------------
    logic signed [lrbm_pkg::XY_W-1:0] x_reg [N+1];
    logic signed [lrbm_pkg::XY_W-1:0] y_reg [N+1];
    logic signed [lrbm_pkg::Z_W-1:0]  z_reg [N+1];
    logic [1:0]                       q_reg [N+1];

    logic [lrbm_pkg::ANGLE_W-1:0] ang_bias;
    logic [1:0]                   quad;
    logic [lrbm_pkg::ANGLE_W-1:0] resid;
    logic [31:0]                  gain_prod;

    assign ang_bias  = ang_reg + lrbm_pkg::OCTANT_BIAS;
    assign quad      = ang_bias[15:14];
    assign resid     = ang_reg - {quad, 14'b0};
    assign gain_prod = 32'(rng_reg[0]) * 32'(lrbm_pkg::INV_GAIN);

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            q_reg[0] <= quad;
            z_reg[0] <= {resid[15], resid, 16'b0};
            x_reg[0] <= {3'b0, gain_prod[31:8]};
            y_reg[0] <= '0;
        end
    end

    // ---------------- CORDIC iterations, one per slot ----------------
    for (genvar k = 0; k < N; k++) begin : g_cordic
        logic signed [lrbm_pkg::XY_W-1:0] xs;
        logic signed [lrbm_pkg::XY_W-1:0] ys;
        logic signed [lrbm_pkg::XY_W-1:0] x_n;
        logic signed [lrbm_pkg::XY_W-1:0] y_n;
        logic signed [lrbm_pkg::Z_W-1:0]  z_n;

        always_comb begin
            xs = x_reg[k] >>> k;
            ys = y_reg[k] >>> k;
            if (!z_reg[k][lrbm_pkg::Z_W-1]) begin
                x_n = x_reg[k] - ys;
                y_n = y_reg[k] + xs;
                z_n = z_reg[k] - lrbm_pkg::ATAN_TURN[k];
            end else begin
                x_n = x_reg[k] + ys;
                y_n = y_reg[k] - xs;
                z_n = z_reg[k] + lrbm_pkg::ATAN_TURN[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k+2]) begin
                x_reg[k+1] <= x_n;
                y_reg[k+1] <= y_n;
                z_reg[k+1] <= z_n;
                q_reg[k+1] <= q_reg[k];
            end
        end
    end

    // ---------------- quadrant rotation and rounding ----------------
    logic signed [lrbm_pkg::XY_W-1:0]  xq;
    logic signed [lrbm_pkg::XY_W-1:0]  yq;
    logic signed [lrbm_pkg::XY_W-1:0]  xr;
    logic signed [lrbm_pkg::XY_W-1:0]  yr;
    logic signed [lrbm_pkg::PXY_W-1:0] px_reg;
    logic signed [lrbm_pkg::PXY_W-1:0] py_reg;

    always_comb begin
        case (q_reg[N])
            2'd1: begin
                xq = -y_reg[N];
                yq =  x_reg[N];
            end
            2'd2: begin
                xq = -x_reg[N];
                yq = -y_reg[N];
            end
            2'd3: begin
                xq =  y_reg[N];
                yq = -x_reg[N];
            end
            default: begin
                xq = x_reg[N];
                yq = y_reg[N];
            end
        endcase
        xr = xq + lrbm_pkg::XY_W'(128);
        yr = yq + lrbm_pkg::XY_W'(128);
    end

    always_ff @(posedge aclk) begin
        if (adv[SRND]) begin
            px_reg <= xr[lrbm_pkg::XY_W-1:8];
            py_reg <= yr[lrbm_pkg::XY_W-1:8];
        end
    end

    // ---------------- box compare ----------------
    logic [lrbm_pkg::ROBOT_SLOTS-1:0] in_box;
    logic                             hit;
    logic [lrbm_pkg::RANGE_W-1:0]     filt_reg;
    logic                             masked_reg;

    for (genvar r = 0; r < lrbm_pkg::ROBOT_SLOTS; r++) begin : g_box
        logic signed [lrbm_pkg::POS_W-1:0]  rx;
        logic signed [lrbm_pkg::POS_W-1:0]  ry;
        logic signed [lrbm_pkg::DIFF_W-1:0] dx;
        logic signed [lrbm_pkg::DIFF_W-1:0] dy;
        logic [lrbm_pkg::DIFF_W-1:0]        adx;
        logic [lrbm_pkg::DIFF_W-1:0]        ady;
        logic [lrbm_pkg::DIFF_W-1:0]        hw_wide;

        always_comb begin
            rx = robot_pos_reg[r][31:16];
            ry = robot_pos_reg[r][15:0];
            dx = lrbm_pkg::DIFF_W'(rx) - lrbm_pkg::DIFF_W'(px_reg);
            dy = lrbm_pkg::DIFF_W'(ry) - lrbm_pkg::DIFF_W'(py_reg);
            adx = dx[lrbm_pkg::DIFF_W-1] ? -dx : dx;
            ady = dy[lrbm_pkg::DIFF_W-1] ? -dy : dy;
            hw_wide = lrbm_pkg::DIFF_W'(half_width_reg);
            in_box[r] = (r < lrbm_pkg::NUM_CHECK) && robot_en_reg[r] &&
                        (adx < hw_wide) && (ady < hw_wide);
        end
    end

    assign hit = act_reg[SRND] && (|in_box);

    always_ff @(posedge aclk) begin
        if (adv[SOUT]) begin
            filt_reg   <= hit ? lrbm_pkg::NO_RETURN : rng_reg[SRND];
            masked_reg <= hit;
        end
    end

    assign m_tdata = filt_reg;
    assign m_tuser = masked_reg;

    // ---------------- assertions ----------------
    a_mask_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == lrbm_pkg::NO_RETURN)
        else $error("masked item without no-return code");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg) && !m_tready |-> !s_tready)
        else $error("input ready while pipeline full and output stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item did not enter the first stage");

    a_last_move: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NSTG-2] && adv[NSTG-1] |=> m_tvalid)
        else $error("item lost between compare input and output register");

endmodule
